@@ design/afr_pkg.sv @@
// Shared types, constants and helper functions for the audio channel router FIFO.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package afr_pkg;

  localparam int CHANNELS    = 8;
  localparam int LANES       = 8;
  localparam int FIFO_DEPTH  = 4096;
  localparam int SAMPLE_BITS = 24;
  localparam int LIMIT_W     = 13;
  localparam int ROUTE_W     = 32;
  localparam int CFG_DATA_W  = 32;
  localparam int SLOT_W      = $clog2(FIFO_DEPTH);
  localparam int FILL_W      = $clog2(FIFO_DEPTH + 1);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef sample_t [CHANNELS-1:0]        src_frame_t;
  typedef sample_t [LANES-1:0]           lane_frame_t;
  typedef logic [SLOT_W-1:0]             slot_t;
  typedef logic [FILL_W-1:0]             fill_t;
  typedef logic [FILL_W:0]               slot_sum_t;
  typedef logic [LIMIT_W-1:0]            limit_t;
  typedef logic [ROUTE_W-1:0]            route_t;
  typedef logic [QPTR_W-1:0]             qptr_t;
  typedef logic [QCNT_W-1:0]             qcnt_t;

  typedef enum logic {
    ACT_CAPTURE = 1'b0,
    ACT_OUTPUT  = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    REG_MIX_ENABLE   = 2'd0,
    REG_ROUTE_MAP    = 2'd1,
    REG_BUFFER_LIMIT = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    src_frame_t  src;
    lane_frame_t dest;
    logic        under;
    logic        ovf;
  } qentry_t;

  typedef struct packed {
    qcnt_t count;
    logic  empty;
    logic  full;
  } qstat_t;

  // Advances a ring slot by up to one full ring length.
  function automatic slot_t slot_add(slot_t s, fill_t n);
    slot_sum_t sum;
    sum = slot_sum_t'(s) + slot_sum_t'(n);
    if (sum >= slot_sum_t'(FIFO_DEPTH)) begin
      sum = sum - slot_sum_t'(FIFO_DEPTH);
    end
    return slot_t'(sum);
  endfunction

  function automatic sample_t sat_add(sample_t a, sample_t b);
    logic signed [SAMPLE_BITS:0] sum;
    sum = {a[SAMPLE_BITS-1], a} + {b[SAMPLE_BITS-1], b};
    if (sum[SAMPLE_BITS] != sum[SAMPLE_BITS-1]) begin
      return sum[SAMPLE_BITS] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                              : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
    return sample_t'(sum);
  endfunction

endpackage

`default_nettype wire

@@ design/audio_channel_router_fifo.sv @@
// Top level of the audio channel router FIFO: configuration registers and module wiring.
// Uses afr_pkg, afr_front, afr_queue and afr_back.
//
// Usage: an input transaction with in_action = 0 stores a captured eight-sample
// frame in a ring of 4096 frames; once buffer_limit frames are held, the oldest
// are dropped to make room and the drop is reported with the next result.
// An input transaction with in_action = 1 carries a destination frame; it pops
// the oldest stored frame (or zeros, flagging underflow) and yields one result
// transaction with the routed or mixed lanes. Captures yield no result.
// Throughput is one input transaction per cycle while in_ready is high. A result
// passes the frame memory read stage, the transaction queue and the output register.
// A four-entry queue sits between front and back; when the receiver stalls it
// fills, and in_ready drops once the queued entries plus any in the memory read
// stage reach four. Configuration is written through cfg_valid/cfg_index/cfg_data;
// the user must write it only while idle, as the block itself does not enforce it.
// Synchronous reset empties the ring, clears the drop flag and sets
// mix_enable = 0, route_map = 0, buffer_limit = 3840. The frame memory is not
// cleared; no reset pass is needed.
`default_nettype none

module audio_channel_router_fifo (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [1:0]                           cfg_index,
  input  wire logic [afr_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 in_action,
  input  wire logic signed [afr_pkg::SAMPLE_BITS-1:0] in_lane_in_0,
  input  wire logic signed [afr_pkg::SAMPLE_BITS-1:0] in_lane_in_1,
  input  wire logic signed [afr_pkg::SAMPLE_BITS-1:0] in_lane_in_2,
  input  wire logic signed [afr_pkg::SAMPLE_BITS-1:0] in_lane_in_3,
  input  wire logic signed [afr_pkg::SAMPLE_BITS-1:0] in_lane_in_4,
  input  wire logic signed [afr_pkg::SAMPLE_BITS-1:0] in_lane_in_5,
  input  wire logic signed [afr_pkg::SAMPLE_BITS-1:0] in_lane_in_6,
  input  wire logic signed [afr_pkg::SAMPLE_BITS-1:0] in_lane_in_7,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [afr_pkg::SAMPLE_BITS-1:0]    out_lane_out_0,
  output logic signed [afr_pkg::SAMPLE_BITS-1:0]    out_lane_out_1,
  output logic signed [afr_pkg::SAMPLE_BITS-1:0]    out_lane_out_2,
  output logic signed [afr_pkg::SAMPLE_BITS-1:0]    out_lane_out_3,
  output logic signed [afr_pkg::SAMPLE_BITS-1:0]    out_lane_out_4,
  output logic signed [afr_pkg::SAMPLE_BITS-1:0]    out_lane_out_5,
  output logic signed [afr_pkg::SAMPLE_BITS-1:0]    out_lane_out_6,
  output logic signed [afr_pkg::SAMPLE_BITS-1:0]    out_lane_out_7,
  output logic                                      out_underflow,
  output logic                                      out_overflow_seen
);

  logic                 mix_enable_r;
  afr_pkg::route_t      route_map_r;
  afr_pkg::limit_t      buffer_limit_r;

  afr_pkg::lane_frame_t in_lanes;
  afr_pkg::lane_frame_t out_lanes;
  afr_pkg::qstat_t      q_stat;
  afr_pkg::qentry_t     q_push_entry;
  afr_pkg::qentry_t     q_head;
  afr_pkg::fill_t       fe_fill;
  logic                 q_push;
  logic                 q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_enable_r   <= 1'b0;
      route_map_r    <= '0;
      buffer_limit_r <= afr_pkg::limit_t'(3840);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        afr_pkg::REG_MIX_ENABLE:   mix_enable_r   <= cfg_data[0];
        afr_pkg::REG_ROUTE_MAP:    route_map_r    <= afr_pkg::route_t'(cfg_data);
        afr_pkg::REG_BUFFER_LIMIT: buffer_limit_r <= cfg_data[afr_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_lanes = {in_lane_in_7, in_lane_in_6, in_lane_in_5, in_lane_in_4,
                     in_lane_in_3, in_lane_in_2, in_lane_in_1, in_lane_in_0};

  afr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_action    (in_action),
    .in_lanes     (in_lanes),
    .buffer_limit (buffer_limit_r),
    .q_stat       (q_stat),
    .push         (q_push),
    .push_entry   (q_push_entry),
    .fill_count   (fe_fill)
  );

  afr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .pop        (q_pop),
    .head       (q_head),
    .stat       (q_stat)
  );

  afr_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (q_head),
    .q_stat            (q_stat),
    .pop               (q_pop),
    .mix_enable        (mix_enable_r),
    .route_map         (route_map_r),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_lanes         (out_lanes),
    .out_underflow     (out_underflow),
    .out_overflow_seen (out_overflow_seen)
  );

  assign out_lane_out_0 = out_lanes[0];
  assign out_lane_out_1 = out_lanes[1];
  assign out_lane_out_2 = out_lanes[2];
  assign out_lane_out_3 = out_lanes[3];
  assign out_lane_out_4 = out_lanes[4];
  assign out_lane_out_5 = out_lanes[5];
  assign out_lane_out_6 = out_lanes[6];
  assign out_lane_out_7 = out_lanes[7];

`ifndef SYNTHESIS
  // The credit check in the front end must never let the queue overrun.
  assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_stat.full)
    else $error("Transaction pushed into a full queue.");

  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_stat.empty)
    else $error("Transaction popped from an empty queue.");

  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_action == afr_pkg::ACT_OUTPUT) |=> q_push)
    else $error("Output transaction did not reach the queue.");

  assert property (@(posedge clk) disable iff (!rst_n)
    fe_fill <= afr_pkg::fill_t'(afr_pkg::FIFO_DEPTH))
    else $error("Frame count exceeds the ring size.");
`endif

endmodule

`default_nettype wire

@@ design/afr_front.sv @@
// Front end: accepts transactions, keeps the ring pointers and holds the frame memory.
// Uses afr_pkg; feeds output transactions to afr_queue.
`default_nettype none

module afr_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_action,
  input  wire afr_pkg::lane_frame_t in_lanes,
  input  wire afr_pkg::limit_t      buffer_limit,
  input  wire afr_pkg::qstat_t      q_stat,
  output logic                      push,
  output afr_pkg::qentry_t          push_entry,
  output afr_pkg::fill_t            fill_count
);

  afr_pkg::slot_t         read_slot_r, read_slot_nxt;
  afr_pkg::fill_t         fill_r, fill_nxt;
  logic                   drop_r, drop_nxt;
  logic                   s1_valid_r;
  afr_pkg::lane_frame_t   s1_dest_r;
  logic                   s1_under_r;
  logic                   s1_ovf_r;
  afr_pkg::src_frame_t    rd_data_r;
  afr_pkg::src_frame_t    frame_mem [afr_pkg::FIFO_DEPTH];

  afr_pkg::fill_t         lim;
  afr_pkg::fill_t         n_drop;
  afr_pkg::slot_t         wr_slot;
  logic                   acc;
  logic                   is_out;
  logic                   at_limit;
  logic                   empty;
  logic                   wr_en;
  logic                   rd_en;

  assign in_ready = (afr_pkg::qcnt_t'(q_stat.count) + afr_pkg::qcnt_t'(s1_valid_r))
                    < afr_pkg::qcnt_t'(afr_pkg::QUEUE_DEPTH);
  assign acc      = in_valid && in_ready;
  assign is_out   = (in_action == afr_pkg::ACT_OUTPUT);
  assign empty    = (fill_r == '0);
  assign wr_en    = acc && !is_out;
  assign rd_en    = acc && is_out && !empty;
  assign wr_slot  = afr_pkg::slot_add(read_slot_r, fill_r);

  always_comb begin
    if (buffer_limit == '0) begin
      lim = afr_pkg::fill_t'(1);
    end else if (32'(buffer_limit) > 32'(afr_pkg::FIFO_DEPTH)) begin
      lim = afr_pkg::fill_t'(afr_pkg::FIFO_DEPTH);
    end else begin
      lim = afr_pkg::fill_t'(buffer_limit);
    end
  end

  assign at_limit = (fill_r >= lim);
  assign n_drop   = fill_r + afr_pkg::fill_t'(1) - lim;

  always_comb begin
    read_slot_nxt = read_slot_r;
    fill_nxt      = fill_r;
    drop_nxt      = drop_r;
    if (acc) begin
      if (!is_out) begin
        if (at_limit) begin
          read_slot_nxt = afr_pkg::slot_add(read_slot_r, n_drop);
          fill_nxt      = lim;
          drop_nxt      = 1'b1;
        end else begin
          fill_nxt      = fill_r + afr_pkg::fill_t'(1);
        end
      end else begin
        drop_nxt = 1'b0;
        if (!empty) begin
          read_slot_nxt = afr_pkg::slot_add(read_slot_r, afr_pkg::fill_t'(1));
          fill_nxt      = fill_r - afr_pkg::fill_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      read_slot_r <= '0;
      fill_r      <= '0;
      drop_r      <= 1'b0;
      s1_valid_r  <= 1'b0;
    end else begin
      read_slot_r <= read_slot_nxt;
      fill_r      <= fill_nxt;
      drop_r      <= drop_nxt;
      s1_valid_r  <= acc && is_out;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && is_out) begin
      s1_dest_r  <= in_lanes;
      s1_under_r <= empty;
      s1_ovf_r   <= drop_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_mem[wr_slot] <= afr_pkg::src_frame_t'(in_lanes);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= frame_mem[read_slot_r];
    end
  end

  assign push             = s1_valid_r;
  assign push_entry.src   = rd_data_r;
  assign push_entry.dest  = s1_dest_r;
  assign push_entry.under = s1_under_r;
  assign push_entry.ovf   = s1_ovf_r;
  assign fill_count       = fill_r;

endmodule

`default_nettype wire

@@ design/afr_queue.sv @@
// Short transaction queue between the front end and the routing back end.
// Uses afr_pkg; register array with read and write pointers.
`default_nettype none

module afr_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire afr_pkg::qentry_t push_entry,
  input  wire logic             pop,
  output afr_pkg::qentry_t      head,
  output afr_pkg::qstat_t       stat
);

  afr_pkg::qentry_t entries_r [afr_pkg::QUEUE_DEPTH];
  afr_pkg::qptr_t   wr_ptr_r;
  afr_pkg::qptr_t   rd_ptr_r;
  afr_pkg::qcnt_t   count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + afr_pkg::qptr_t'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + afr_pkg::qptr_t'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + afr_pkg::qcnt_t'(1);
      end else if (pop && !push) begin
        count_r <= count_r - afr_pkg::qcnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

  assign head       = entries_r[rd_ptr_r];
  assign stat.count = count_r;
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == afr_pkg::qcnt_t'(afr_pkg::QUEUE_DEPTH));

endmodule

`default_nettype wire

@@ design/afr_back.sv @@
// Back end: routes or mixes source samples onto destination lanes and holds the result.
// Uses afr_pkg; pops transactions from afr_queue.
`default_nettype none

module afr_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire afr_pkg::qentry_t head,
  input  wire afr_pkg::qstat_t  q_stat,
  output logic                  pop,
  input  wire logic             mix_enable,
  input  wire afr_pkg::route_t  route_map,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output afr_pkg::lane_frame_t  out_lanes,
  output logic                  out_underflow,
  output logic                  out_overflow_seen
);

  logic                 out_valid_r;
  afr_pkg::lane_frame_t lanes_r;
  logic                 under_r;
  logic                 ovf_r;
  afr_pkg::sample_t     lane [afr_pkg::LANES];
  afr_pkg::sample_t     src_s;
  logic [3:0]           nib;
  afr_pkg::lane_frame_t lanes_nxt;

  assign pop = !q_stat.empty && (!out_valid_r || out_ready);

  // Sources are applied in ascending order, so without mixing the highest-numbered source wins.
  always_comb begin
    for (int i = 0; i < afr_pkg::LANES; i++) begin
      lane[i] = head.dest[i];
    end
    src_s = '0;
    nib   = '0;
    for (int c = 0; c < afr_pkg::CHANNELS; c++) begin
      src_s = head.under ? afr_pkg::sample_t'(0) : afr_pkg::sample_t'(head.src[c]);
      nib   = route_map[4*c +: 4];
      if (nib[3] && (int'(nib[2:0]) < afr_pkg::CHANNELS)) begin
        if (mix_enable) begin
          lane[nib[2:0]] = afr_pkg::sat_add(lane[nib[2:0]], src_s);
        end else begin
          lane[nib[2:0]] = src_s;
        end
      end
    end
    for (int i = 0; i < afr_pkg::LANES; i++) begin
      lanes_nxt[i] = lane[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      lanes_r <= lanes_nxt;
      under_r <= head.under;
      ovf_r   <= head.ovf;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_lanes         = lanes_r;
  assign out_underflow     = under_r;
  assign out_overflow_seen = ovf_r;

endmodule

`default_nettype wire
